### hw/rtl/sleep_wakeup_alarm_queue_core_macros.svh
// assertion macros for the sleep/wakeup alarm queue
// used by the core top level; needs no other file
`ifndef SLEEP_WAKEUP_ALARM_QUEUE_CORE_MACROS_SVH
`define SLEEP_WAKEUP_ALARM_QUEUE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define SWA_AST_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SWA_AST_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SWA_AST_IMPL(label, ante, cons)
`define SWA_AST_NEXT(label, ante, cons)
`endif
`endif

### hw/rtl/swa_pkg.sv
// shared types and constants of the sleep/wakeup alarm queue
// no dependencies
package swa_pkg;
    localparam int SLOTS       = 16;
    localparam int MAX_RES     = 16;
    localparam int IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W       = $clog2(SLOTS + 1);
    localparam int WB_IDX_W    = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;
    localparam int NW_W        = $clog2(MAX_RES + 1);
    localparam int TICK_W      = 63;
    localparam int TID_W       = 8;

    localparam logic [TICK_W-1:0] TICK_MAX = '1;

    localparam logic OP_SLEEP = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    localparam logic [2:0] ST_STORED = 3'd0;
    localparam logic [2:0] ST_FULL   = 3'd1;
    localparam logic [2:0] ST_IDLE   = 3'd2;
    localparam logic [2:0] ST_WOKEN  = 3'd3;
    localparam logic [2:0] ST_NONE   = 3'd4;

    typedef struct packed {
        logic              operation;
        logic [TID_W-1:0]  thread_id;
        logic [TICK_W-1:0] tick_value;
    } t_in;

    typedef struct packed {
        logic [2:0]        status;
        logic [TID_W-1:0]  woken_thread;
        logic [TICK_W-1:0] next_wakeup;
        logic              last;
    } t_out;

    typedef struct packed {
        logic [TID_W-1:0]  thread;
        logic [TICK_W-1:0] wake_tick;
    } t_entry;
endpackage

### hw/rtl/sleep_wakeup_alarm_queue_core.sv
// top level of the sleep/wakeup alarm queue: control, scan and result path
// depends on swa_pkg, swa_entry_mem, swa_wake_mem and the assertion macros
//
// channel    signals                   transfer
// command    start, busy, i_cmd        start high and busy low at a clock edge
// result     o_strobe, o_result        o_strobe high for one cycle, always taken
// config     i_cfg_we, i_cfg_data      i_cfg_we high at a clock edge
//
// sleep: result in the cycle after the transfer, busy stays low, next command any cycle
// tick: busy while the entries are scanned, then while the woken ids are sent if any are due;
//   one entry per cycle through the single read port of the entry memory, then one woken
//   id per cycle from the buffer
// reset: synchronous, no clearing pass; the receiver cannot stall
`include "sleep_wakeup_alarm_queue_core_macros.svh"

module sleep_wakeup_alarm_queue_core
    import swa_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_in              i_cmd,
    output logic             o_strobe,
    output t_out             o_result,
    input  logic             i_cfg_we,
    input  logic [TID_W-1:0] i_cfg_data
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [TICK_W-1:0] r_earliest, n_earliest;
    logic [TID_W-1:0]  r_idle_id, n_idle_id;
    logic              r_strobe, n_strobe;
    logic              r_pend, n_pend;
    logic              r_opend, n_opend;
    logic [CNT_W-1:0]  r_rd_idx, n_rd_idx;
    logic [CNT_W-1:0]  r_keep, n_keep;
    logic [NW_W-1:0]   r_nwoken, n_nwoken;
    logic [NW_W-1:0]   r_out_idx, n_out_idx;
    logic              r_olast, n_olast;
    logic [TICK_W-1:0] r_tick, n_tick;
    logic [TICK_W-1:0] r_least, n_least;
    t_out              r_res, n_res;

    logic              accept;
    logic              rd_issue;
    logic              due;
    logic              wb_issue;
    logic              ent_we;
    logic [IDX_W-1:0]  ent_waddr;
    t_entry            ent_wdata;
    t_entry            ent_rdata;
    logic              wb_we;
    logic [TID_W-1:0]  wb_rdata;

    assign busy     = (r_state != S_IDLE);
    assign accept   = start && !busy;
    assign rd_issue = (r_state == S_SCAN) && (r_rd_idx < r_count);
    assign due      = r_pend && (ent_rdata.wake_tick <= r_tick)
                      && (r_nwoken < NW_W'(MAX_RES));
    assign wb_issue = (r_state == S_EMIT) && (r_out_idx < r_nwoken);
    assign wb_we    = due;

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_earliest = r_earliest;
        n_idle_id  = i_cfg_we ? i_cfg_data : r_idle_id;
        n_strobe   = 1'b0;
        n_pend     = rd_issue;
        n_opend    = wb_issue;
        n_rd_idx   = rd_issue ? r_rd_idx + CNT_W'(1) : r_rd_idx;
        n_keep     = r_keep;
        n_nwoken   = r_nwoken;
        n_out_idx  = wb_issue ? r_out_idx + NW_W'(1) : r_out_idx;
        n_olast    = (r_out_idx == r_nwoken - NW_W'(1));
        n_tick     = r_tick;
        n_least    = r_least;
        n_res      = r_res;
        ent_we     = 1'b0;
        ent_waddr  = r_keep[IDX_W-1:0];
        ent_wdata  = ent_rdata;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_res.woken_thread = '0;
                    n_res.last         = 1'b1;
                    if (i_cmd.operation == OP_TICK) begin
                        n_state  = S_SCAN;
                        n_tick   = i_cmd.tick_value;
                        n_rd_idx = '0;
                        n_keep   = '0;
                        n_nwoken = '0;
                        n_least  = TICK_MAX;
                    end else if (i_cmd.thread_id == r_idle_id) begin
                        n_strobe          = 1'b1;
                        n_res.status      = ST_IDLE;
                        n_res.next_wakeup = r_earliest;
                    end else if (r_count >= CNT_W'(SLOTS)) begin
                        n_strobe          = 1'b1;
                        n_res.status      = ST_FULL;
                        n_res.next_wakeup = r_earliest;
                    end else begin
                        ent_we              = 1'b1;
                        ent_waddr           = r_count[IDX_W-1:0];
                        ent_wdata.thread    = i_cmd.thread_id;
                        ent_wdata.wake_tick = i_cmd.tick_value;
                        n_count             = r_count + CNT_W'(1);
                        if (i_cmd.tick_value < r_earliest) begin
                            n_earliest = i_cmd.tick_value;
                        end
                        n_strobe          = 1'b1;
                        n_res.status      = ST_STORED;
                        n_res.next_wakeup = n_earliest;
                    end
                end
            end
            S_SCAN: begin
                if (due) begin
                    n_nwoken = r_nwoken + NW_W'(1);
                end else if (r_pend) begin
                    ent_we = 1'b1;
                    n_keep = r_keep + CNT_W'(1);
                    if (ent_rdata.wake_tick < r_least) begin
                        n_least = ent_rdata.wake_tick;
                    end
                end
                if (!rd_issue && !r_pend) begin
                    n_count    = r_keep;
                    n_earliest = r_least;
                    n_out_idx  = '0;
                    if (r_nwoken == '0) begin
                        n_state           = S_IDLE;
                        n_strobe          = 1'b1;
                        n_res.status      = ST_NONE;
                        n_res.woken_thread = '0;
                        n_res.next_wakeup = r_least;
                        n_res.last        = 1'b1;
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (r_opend) begin
                    n_strobe           = 1'b1;
                    n_res.status       = ST_WOKEN;
                    n_res.woken_thread = wb_rdata;
                    n_res.next_wakeup  = r_earliest;
                    n_res.last         = r_olast;
                end
                if (!wb_issue && !r_opend) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_earliest <= TICK_MAX;
            r_idle_id  <= '0;
            r_strobe   <= 1'b0;
            r_pend     <= 1'b0;
            r_opend    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_earliest <= n_earliest;
            r_idle_id  <= n_idle_id;
            r_strobe   <= n_strobe;
            r_pend     <= n_pend;
            r_opend    <= n_opend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx  <= n_rd_idx;
        r_keep    <= n_keep;
        r_nwoken  <= n_nwoken;
        r_out_idx <= n_out_idx;
        r_olast   <= n_olast;
        r_tick    <= n_tick;
        r_least   <= n_least;
        r_res     <= n_res;
    end

    swa_entry_mem u_entry_mem (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (ent_waddr),
        .i_wdata (ent_wdata),
        .i_raddr (r_rd_idx[IDX_W-1:0]),
        .o_rdata (ent_rdata)
    );

    swa_wake_mem u_wake_mem (
        .i_clk   (i_clk),
        .i_we    (wb_we),
        .i_waddr (r_nwoken[WB_IDX_W-1:0]),
        .i_wdata (ent_rdata.thread),
        .i_raddr (r_out_idx[WB_IDX_W-1:0]),
        .o_rdata (wb_rdata)
    );

    assign o_strobe = r_strobe;
    assign o_result = r_res;

    `SWA_AST_IMPL(a_no_strobe_in_scan, r_state == S_SCAN, !o_strobe)
    `SWA_AST_IMPL(a_count_in_range, 1'b1, r_count <= CNT_W'(SLOTS))
    `SWA_AST_IMPL(a_keep_behind_read, r_state == S_SCAN, r_keep <= r_rd_idx)
    `SWA_AST_NEXT(a_tick_goes_busy, accept && (i_cmd.operation == OP_TICK), busy)
    `SWA_AST_NEXT(a_sleep_one_result, accept && (i_cmd.operation == OP_SLEEP), o_strobe && o_result.last)
endmodule

### hw/rtl/swa_entry_mem.sv
// entry store: thread id and wake tick per slot, one write and one read port
// depends on swa_pkg
module swa_entry_mem
    import swa_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_waddr,
    input  t_entry           i_wdata,
    input  logic [IDX_W-1:0] i_raddr,
    output t_entry           o_rdata
);
    t_entry r_mem [SLOTS];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### hw/rtl/swa_wake_mem.sv
// buffer of woken thread ids collected during a tick scan
// depends on swa_pkg
module swa_wake_mem
    import swa_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [WB_IDX_W-1:0] i_waddr,
    input  logic [TID_W-1:0]    i_wdata,
    input  logic [WB_IDX_W-1:0] i_raddr,
    output logic [TID_W-1:0]    o_rdata
);
    logic [TID_W-1:0] r_mem [MAX_RES];
    logic [TID_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
